// File: hw/rtl/assert_macros.svh
// Assertion helpers for the slot queue report packer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General clocked assertion, disabled while reset is asserted.
`define SQRP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// Same-cycle implication from a condition to a consequence.
`define SQRP_ASSERT_IMPLIES(label, clk, rst_n, cond, cons) \
    `SQRP_ASSERT(label, clk, rst_n, (cond) |-> (cons))

// Next-cycle implication from a condition to a consequence.
`define SQRP_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    `SQRP_ASSERT(label, clk, rst_n, (cond) |=> (cons))

`endif

// File: hw/rtl/sqrp_pkg.sv
package sqrp_pkg;

    // Table geometry and report size.
    localparam int SLOT_COUNT   = 8;
    localparam int REPORT_LIMIT = 4;
    localparam int PAYLOAD_BITS = 56;

    localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int COUNT_W    = $clog2(REPORT_LIMIT + 1);
    localparam int CFG_IDX_W  = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MARKER_NATIVE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MARKER_CONSOLE_A = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MARKER_CONSOLE_B = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_IDENT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_KIND      = 3'd4;

    // Operation, host and item codes.
    localparam logic       OP_ENQUEUE     = 1'b0;
    localparam logic       OP_ENCODE      = 1'b1;
    localparam logic [1:0] HOST_NATIVE    = 2'd0;
    localparam logic [1:0] HOST_CONSOLE_A = 2'd1;
    localparam logic [1:0] HOST_CONSOLE_B = 2'd2;
    localparam logic       ITEM_STATUS    = 1'b0;
    localparam logic       ITEM_RECORD    = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [7:0]  record_flags;
        logic [55:0] record_payload;
        logic [1:0]  host_select;
    } t_in;

    typedef struct packed {
        logic        item_kind;
        logic        success;
        logic [7:0]  host_marker;
        logic [7:0]  header_ident;
        logic [7:0]  header_type;
        logic [2:0]  record_count;
        logic [7:0]  out_flags;
        logic [55:0] out_payload;
        logic        still_pending;
        logic        last;
    } t_out;

    typedef struct packed {
        logic [7:0] marker_native;
        logic [7:0] marker_console_a;
        logic [7:0] marker_console_b;
        logic [7:0] report_ident;
        logic [7:0] report_kind_byte;
    } t_cfg;

    typedef logic [PAYLOAD_BITS-1:0] t_payload;

    // One stored record: flags and payload word.
    typedef struct packed {
        logic [7:0] flags;
        t_payload   payload;
    } t_slot;

    // Request from the sequencer to the slot memory.
    typedef struct packed {
        logic                  we;
        logic [SLOT_IDX_W-1:0] waddr;
        t_slot                 wdata;
        logic                  re;
        logic [SLOT_IDX_W-1:0] raddr;
    } t_ram_req;

endpackage

// File: hw/rtl/sqrp_cfg_regs.sv
module sqrp_cfg_regs
    import sqrp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    // Writes are always taken; an index beyond the list is dropped.
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.marker_native    <= 8'd1;
            r_cfg.marker_console_a <= 8'd2;
            r_cfg.marker_console_b <= 8'd3;
            r_cfg.report_ident     <= 8'd0;
            r_cfg.report_kind_byte <= 8'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MARKER_NATIVE:    r_cfg.marker_native    <= i_cfg_data;
                CFG_MARKER_CONSOLE_A: r_cfg.marker_console_a <= i_cfg_data;
                CFG_MARKER_CONSOLE_B: r_cfg.marker_console_b <= i_cfg_data;
                CFG_REPORT_IDENT:     r_cfg.report_ident     <= i_cfg_data;
                CFG_REPORT_KIND:      r_cfg.report_kind_byte <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

// File: hw/rtl/sqrp_slot_ram.sv
module sqrp_slot_ram
    import sqrp_pkg::*;
(
    input  logic     i_clk,
    input  t_ram_req i_req,
    output t_slot    o_rdata
);

    t_slot r_mem [SLOT_COUNT];
    t_slot r_rdata;

    assign o_rdata = r_rdata;

    // One write port and one read port with registered read data.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

endmodule

// File: hw/rtl/sqrp_ctrl.sv
module sqrp_ctrl
    import sqrp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in      i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out     o_out_data,
    output t_ram_req o_ram_req,
    input  t_slot    i_ram_rdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_SEND
    } t_state;

    t_state                r_state, n_state;
    t_in                   r_item, n_item;
    logic [SLOT_COUNT-1:0] r_occ, n_occ;
    logic [SLOT_COUNT-1:0] r_drain, n_drain;
    logic                  r_pend, n_pend;
    logic                  r_out_valid, n_out_valid;
    t_out                  r_out, n_out;

    logic                  free_hit;
    logic [SLOT_IDX_W-1:0] free_idx;
    logic [SLOT_IDX_W-1:0] drain_idx;
    logic [SLOT_COUNT-1:0] drain_mask;
    logic [COUNT_W-1:0]    drain_cnt;
    logic [7:0]            marker;
    logic                  enq_ok;
    logic                  out_free;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign out_free    = !r_out_valid || !i_out_stall;

    // Lowest free slot for an enqueue.
    always_comb begin
        free_hit = 1'b0;
        free_idx = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!r_occ[i]) begin
                free_hit = 1'b1;
                free_idx = SLOT_IDX_W'(i);
            end
        end
    end

    // Lowest slot still waiting to be drained.
    always_comb begin
        drain_idx = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (r_drain[i]) begin
                drain_idx = SLOT_IDX_W'(i);
            end
        end
    end

    // First occupied slots, up to the report limit, in index order.
    always_comb begin
        drain_mask = '0;
        drain_cnt  = '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (r_occ[i] && (drain_cnt < COUNT_W'(REPORT_LIMIT))) begin
                drain_mask[i] = 1'b1;
                drain_cnt     = drain_cnt + 1'b1;
            end
        end
    end

    // Host marker selection; the invalid host reads as zero.
    always_comb begin
        case (r_item.host_select)
            HOST_NATIVE:    marker = i_cfg.marker_native;
            HOST_CONSOLE_A: marker = i_cfg.marker_console_a;
            HOST_CONSOLE_B: marker = i_cfg.marker_console_b;
            default:        marker = 8'd0;
        endcase
    end

    assign enq_ok = (r_item.record_flags != 8'd0) && free_hit;

    // Memory requests: the store happens with the status item, and a read
    // is issued in S_READ ahead of each drained record item sent from S_SEND.
    always_comb begin
        o_ram_req               = '0;
        o_ram_req.waddr         = free_idx;
        o_ram_req.wdata.flags   = r_item.record_flags;
        o_ram_req.wdata.payload = t_payload'(r_item.record_payload);
        o_ram_req.raddr         = drain_idx;
        o_ram_req.we = (r_state == S_EXEC) && out_free
                       && (r_item.operation == OP_ENQUEUE) && enq_ok;
        o_ram_req.re = (r_state == S_READ);
    end

    // Sequencer next state.
    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_occ       = r_occ;
        n_drain     = r_drain;
        n_pend      = r_pend;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in_data;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '0;
                    n_out.item_kind = ITEM_STATUS;
                    if (r_item.operation == OP_ENQUEUE) begin
                        if (enq_ok) begin
                            n_occ[free_idx] = 1'b1;
                        end
                        n_out.success       = enq_ok;
                        n_out.still_pending = (|r_occ) || enq_ok;
                        n_out.last          = 1'b1;
                        n_state             = S_IDLE;
                    end else if ((marker != 8'd0) && (drain_cnt != '0)) begin
                        // Header first, then the drained records.
                        n_occ               = r_occ & ~drain_mask;
                        n_drain             = drain_mask;
                        n_pend              = |(r_occ & ~drain_mask);
                        n_out.success       = 1'b1;
                        n_out.host_marker   = marker;
                        n_out.header_ident  = i_cfg.report_ident;
                        n_out.header_type   = i_cfg.report_kind_byte;
                        n_out.record_count  = 3'(drain_cnt);
                        n_out.still_pending = |(r_occ & ~drain_mask);
                        n_state             = S_READ;
                    end else begin
                        // Invalid host or empty table gives one failure item.
                        n_out.still_pending = |r_occ;
                        n_out.last          = 1'b1;
                        n_state             = S_IDLE;
                    end
                end
            end
            S_READ: begin
                n_drain[drain_idx] = 1'b0;
                n_state            = S_SEND;
            end
            S_SEND: begin
                if (out_free) begin
                    n_out_valid         = 1'b1;
                    n_out               = '0;
                    n_out.item_kind     = ITEM_RECORD;
                    n_out.success       = 1'b1;
                    n_out.out_flags     = i_ram_rdata.flags;
                    n_out.out_payload   = 56'(i_ram_rdata.payload);
                    n_out.still_pending = r_pend;
                    n_out.last          = (r_drain == '0);
                    n_state             = (r_drain == '0) ? S_IDLE : S_READ;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State, occupancy and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_drain     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_drain     <= n_drain;
            r_out_valid <= n_out_valid;
        end
        r_item <= n_item;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

endmodule

// File: hw/rtl/slot_queue_report_packer_core.sv
// Channel   Direction  Handshake          Payload
// in        input      valid / stall      t_in  (operation, flags, payload, host)
// out       output     valid / stall      t_out (one result item per transfer)
// cfg       input      valid / ready      register index, 8-bit data
//
// An enqueue passes through the item register to its status item. An encode
// gives its header and then one record item per drained record, since every
// record is fetched through the single read port of the slot memory.
// Reset is synchronous; slot occupancy is cleared at once, no clearing pass.
// The next input is taken once the last result is loaded in the output
// register, even while that result is stalled; an output stall holds the
// sequencer in place.
module slot_queue_report_packer_core
    import sqrp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in                  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out                 o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data
);

    t_cfg     cfg;
    t_ram_req ram_req;
    t_slot    ram_rdata;

    // Configuration registers.
    sqrp_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Record storage.
    sqrp_slot_ram u_slot_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    // Sequencer with occupancy bits and the output register.
    sqrp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .o_ram_req   (ram_req),
        .i_ram_rdata (ram_rdata)
    );

endmodule

// File: hw/rtl/sqrp_checker.sv
`include "assert_macros.svh"

module sqrp_checker
    import sqrp_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input t_out o_out_data
);

    logic out_held;
    logic record_item;
    logic record_shape;
    logic fail_item;
    logic fail_shape;

    assign out_held     = o_out_valid && i_out_stall;
    assign record_item  = o_out_valid && (o_out_data.item_kind == ITEM_RECORD);
    assign record_shape = o_out_data.success && (o_out_data.record_count == 3'd0)
                          && (o_out_data.host_marker == 8'd0);
    assign fail_item    = o_out_valid && (o_out_data.item_kind == ITEM_STATUS)
                          && !o_out_data.success;
    assign fail_shape   = o_out_data.last && (o_out_data.host_marker == 8'd0)
                          && (o_out_data.record_count == 3'd0);

    // A stalled result item stays in place.
    `SQRP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_held, o_out_valid && $stable(o_out_data))

    // After an input transfer the block works on it before taking another.
    `SQRP_ASSERT_NEXT(a_in_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

    // A drained record item is a success with empty header fields.
    `SQRP_ASSERT_IMPLIES(a_record_item, i_clk, i_rst_n, record_item, record_shape)

    // A failed status item carries no header and ends its input.
    `SQRP_ASSERT_IMPLIES(a_fail_item, i_clk, i_rst_n, fail_item, fail_shape)

endmodule

bind slot_queue_report_packer_core sqrp_checker u_sqrp_checker (.*);

// File: sim/slot_queue_report_packer_core_tb.sv
module slot_queue_report_packer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sqrp_pkg::*;

    // Host code that selects no marker register.
    localparam logic [1:0] HOST_INVALID = 2'd3;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_SEND_GAP = 30;
    localparam int MAX_PRINTED = 40;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    t_in                  i_in_data = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out                 o_out_data;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [7:0]           i_cfg_data = '0;

    // Mirror of the slot table and the header registers.
    logic [7:0] slot_flags [SLOT_COUNT];
    t_payload   slot_payload [SLOT_COUNT];
    t_cfg       header_regs;

    // Result items still owed by the block, oldest first.
    t_out report_items [$];

    int errors = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int n_requests = 0;
    int n_stored = 0;
    int n_refused = 0;
    int n_reports = 0;
    int n_failed_encodes = 0;
    int n_drained = 0;
    int n_checked = 0;

    slot_queue_report_packer_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock with a 2 ns period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Prints one line per mismatch, up to a limit, and counts every one.
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        if (errors <= MAX_PRINTED) begin
            $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        end
    endtask

    function automatic logic table_busy();
        logic busy;
        busy = 1'b0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (slot_flags[i] != 8'd0) begin
                busy = 1'b1;
            end
        end
        return busy;
    endfunction

    // Applies one accepted request to the mirrored table and queues the
    // result items that it produces.
    task automatic step_slot_table(input t_in req);
        logic       stored;
        logic [7:0] marker;
        logic       pend;
        int         count;
        logic [7:0] drained_flags [REPORT_LIMIT];
        t_payload   drained_payload [REPORT_LIMIT];
        t_out       item;

        n_requests++;
        item = '0;
        if (req.operation == OP_ENQUEUE) begin
            stored = 1'b0;
            if (req.record_flags != 8'd0) begin
                for (int i = 0; i < SLOT_COUNT && !stored; i++) begin
                    if (slot_flags[i] == 8'd0) begin
                        slot_flags[i] = req.record_flags;
                        slot_payload[i] = req.record_payload[PAYLOAD_BITS-1:0];
                        stored = 1'b1;
                    end
                end
            end
            if (stored) n_stored++;
            else n_refused++;
            item.item_kind = ITEM_STATUS;
            item.success = stored;
            item.still_pending = table_busy();
            item.last = 1'b1;
            report_items.push_back(item);
        end else begin
            case (req.host_select)
                HOST_NATIVE: begin
                    marker = header_regs.marker_native;
                end
                HOST_CONSOLE_A: begin
                    marker = header_regs.marker_console_a;
                end
                HOST_CONSOLE_B: begin
                    marker = header_regs.marker_console_b;
                end
                default: begin
                    marker = 8'd0;
                end
            endcase
            count = 0;
            if (marker != 8'd0) begin
                for (int i = 0; i < SLOT_COUNT && count < REPORT_LIMIT; i++) begin
                    if (slot_flags[i] != 8'd0) begin
                        drained_flags[count] = slot_flags[i];
                        drained_payload[count] = slot_payload[i];
                        slot_flags[i] = 8'd0;
                        count++;
                    end
                end
            end
            pend = table_busy();
            if (count == 0) begin
                // Invalid host or nothing to drain: a single failure header.
                n_failed_encodes++;
                item.item_kind = ITEM_STATUS;
                item.still_pending = pend;
                item.last = 1'b1;
                report_items.push_back(item);
            end else begin
                n_reports++;
                n_drained += count;
                item.item_kind = ITEM_STATUS;
                item.success = 1'b1;
                item.host_marker = marker;
                item.header_ident = header_regs.report_ident;
                item.header_type = header_regs.report_kind_byte;
                item.record_count = 3'(count);
                item.still_pending = pend;
                report_items.push_back(item);
                for (int k = 0; k < count; k++) begin
                    item = '0;
                    item.item_kind = ITEM_RECORD;
                    item.success = 1'b1;
                    item.out_flags = drained_flags[k];
                    item.out_payload = 56'(drained_payload[k]);
                    item.still_pending = pend;
                    item.last = (k + 1 == count);
                    report_items.push_back(item);
                end
            end
        end
    endtask

    // Compares every accepted result item with the oldest one owed.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (report_items.size() == 0) begin
                report_mismatch("unexpected result item", 64'(o_out_data.out_payload), 64'd0);
            end else begin
                want = report_items.pop_front();
                n_checked++;
                if (o_out_data.item_kind !== want.item_kind)
                    report_mismatch("item_kind", o_out_data.item_kind, want.item_kind);
                if (o_out_data.success !== want.success)
                    report_mismatch("success", o_out_data.success, want.success);
                if (o_out_data.host_marker !== want.host_marker)
                    report_mismatch("host_marker", o_out_data.host_marker, want.host_marker);
                if (o_out_data.header_ident !== want.header_ident)
                    report_mismatch("header_ident", o_out_data.header_ident,
                                    want.header_ident);
                if (o_out_data.header_type !== want.header_type)
                    report_mismatch("header_type", o_out_data.header_type, want.header_type);
                if (o_out_data.record_count !== want.record_count)
                    report_mismatch("record_count", o_out_data.record_count,
                                    want.record_count);
                if (o_out_data.out_flags !== want.out_flags)
                    report_mismatch("out_flags", o_out_data.out_flags, want.out_flags);
                if (o_out_data.out_payload !== want.out_payload)
                    report_mismatch("out_payload", o_out_data.out_payload, want.out_payload);
                if (o_out_data.still_pending !== want.still_pending)
                    report_mismatch("still_pending", o_out_data.still_pending,
                                    want.still_pending);
                if (o_out_data.last !== want.last)
                    report_mismatch("last", o_out_data.last, want.last);
            end
        end
    end

    // Output stall: a requested long hold first, otherwise random stalls.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Ends the run when no transfer of any kind happens for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $realtime, QUIET_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Offers one request after a random gap and waits for its transfer.
    task automatic send_request(input t_in req);
        int gap;
        gap = 0;
        while (gap < MAX_SEND_GAP && $urandom_range(0, 99) < send_idle_pct) begin
            gap++;
        end
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        step_slot_table(req);
    endtask

    // Stops offering and waits until every owed result has arrived.
    task automatic wait_for_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (report_items.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_MARKER_NATIVE: begin
                header_regs.marker_native = value;
            end
            CFG_MARKER_CONSOLE_A: begin
                header_regs.marker_console_a = value;
            end
            CFG_MARKER_CONSOLE_B: begin
                header_regs.marker_console_b = value;
            end
            CFG_REPORT_IDENT: begin
                header_regs.report_ident = value;
            end
            CFG_REPORT_KIND: begin
                header_regs.report_kind_byte = value;
            end
            default: begin
            end
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_in make_request(input logic op, input logic [7:0] flags,
                                         input logic [55:0] payload, input logic [1:0] host);
        t_in req;
        req.operation = op;
        req.record_flags = flags;
        req.record_payload = payload;
        req.host_select = host;
        return req;
    endfunction

    // Random request; the table fill level follows enqueue_pct.
    function automatic t_in random_request(input int enqueue_pct);
        t_in req;
        logic [55:0] payload;
        payload = 56'({$urandom, $urandom});
        case ($urandom_range(0, 15))
            0: payload = '0;
            1: payload = '1;
            default: begin
            end
        endcase
        req.operation = ($urandom_range(0, 99) < enqueue_pct) ? OP_ENQUEUE : OP_ENCODE;
        req.record_flags = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
        req.record_payload = payload;
        req.host_select = ($urandom_range(0, 7) == 0) ? HOST_INVALID
                                                      : 2'($urandom_range(0, 2));
        return req;
    endfunction

    // Random marker, zero now and then so that a host becomes invalid.
    function automatic logic [7:0] random_marker();
        return ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
    endfunction

    task automatic load_random_registers();
        write_register(CFG_MARKER_NATIVE, random_marker());
        write_register(CFG_MARKER_CONSOLE_A, random_marker());
        write_register(CFG_MARKER_CONSOLE_B, random_marker());
        write_register(CFG_REPORT_IDENT, 8'($urandom_range(0, 255)));
        write_register(CFG_REPORT_KIND, 8'($urandom_range(0, 255)));
    endtask

    // Encodes on an empty table, a zero-flags enqueue and an invalid host,
    // all with the register values after reset.
    task automatic test_empty_table();
        send_request(make_request(OP_ENCODE, 8'd0, '0, HOST_NATIVE));
        send_request(make_request(OP_ENQUEUE, 8'd0, '1, HOST_NATIVE));
        send_request(make_request(OP_ENCODE, 8'hFF, '1, HOST_INVALID));
    endtask

    // Fills every slot, overflows once, then drains in two reports.
    task automatic test_fill_and_drain();
        send_request(make_request(OP_ENQUEUE, 8'h01, '0, HOST_NATIVE));
        send_request(make_request(OP_ENQUEUE, 8'hFF, '1, HOST_INVALID));
        send_request(make_request(OP_ENQUEUE, 8'h80, 56'hAA_AAAA_AAAA_AAAA, HOST_NATIVE));
        send_request(make_request(OP_ENQUEUE, 8'h7F, 56'h55_5555_5555_5555, HOST_CONSOLE_A));
        for (int i = 0; i < 4; i++) begin
            send_request(make_request(OP_ENQUEUE, 8'($urandom_range(1, 255)),
                                      56'({$urandom, $urandom}), HOST_CONSOLE_B));
        end
        // The table is full now, so this one is refused.
        send_request(make_request(OP_ENQUEUE, 8'h3C, '1, HOST_NATIVE));
        send_request(make_request(OP_ENCODE, 8'h00, '0, HOST_INVALID));
        send_request(make_request(OP_ENCODE, 8'h00, '0, HOST_NATIVE));
        send_request(make_request(OP_ENCODE, 8'h00, '0, HOST_CONSOLE_A));
        send_request(make_request(OP_ENCODE, 8'h00, '0, HOST_CONSOLE_B));
        wait_for_results();
    endtask

    // Register extremes, including a zero marker that disables its host.
    task automatic test_register_extremes();
        write_register(CFG_MARKER_NATIVE, 8'hFF);
        write_register(CFG_MARKER_CONSOLE_A, 8'h00);
        write_register(CFG_MARKER_CONSOLE_B, 8'h01);
        write_register(CFG_REPORT_IDENT, 8'hFF);
        write_register(CFG_REPORT_KIND, 8'hFF);
        send_request(make_request(OP_ENQUEUE, 8'h5A, 56'h12_3456_789A_BCDE, HOST_NATIVE));
        send_request(make_request(OP_ENCODE, 8'h00, '0, HOST_CONSOLE_A));
        send_request(make_request(OP_ENCODE, 8'h00, '0, HOST_CONSOLE_B));
        send_request(make_request(OP_ENQUEUE, 8'hA5, '1, HOST_CONSOLE_A));
        send_request(make_request(OP_ENCODE, 8'h00, '0, HOST_NATIVE));
        send_request(make_request(OP_ENCODE, 8'h00, '0, HOST_NATIVE));
        wait_for_results();
        write_register(CFG_REPORT_IDENT, 8'h00);
        write_register(CFG_REPORT_KIND, 8'h00);
    endtask

    // Random traffic under one idle mix, with fill and drain bursts.
    task automatic test_random_traffic(input int send_pct, input int stall_pct_v,
                                       input int n_items);
        load_random_registers();
        for (int i = 0; i < n_items; i++) begin
            // Every fourth stretch of 12 requests runs without idling.
            if ((i / 12) % 4 == 3) begin
                send_idle_pct = 0;
                stall_pct = 0;
            end else begin
                send_idle_pct = send_pct;
                stall_pct = stall_pct_v;
            end
            send_request(random_request(((i / 16) % 2 == 0) ? 75 : 35));
        end
        wait_for_results();
        send_idle_pct = 0;
        stall_pct = 0;
    endtask

    // The receiver holds off for a long stretch while requests keep coming,
    // so that the block fills up and stalls its input.
    task automatic test_output_hold();
        send_idle_pct = 0;
        stall_pct = 0;
        hold_left = HOLD_CYCLES;
        for (int i = 0; i < 20; i++) begin
            send_request(random_request(60));
        end
        wait_for_results();
    endtask

    // The sender pauses until every result is in, then resumes.
    task automatic test_sender_pause();
        send_idle_pct = 19;
        stall_pct = 19;
        for (int i = 0; i < 6; i++) begin
            send_request(random_request(70));
        end
        wait_for_results();
        for (int i = 0; i < 6; i++) begin
            send_request(random_request(40));
        end
        wait_for_results();
        send_idle_pct = 0;
        stall_pct = 0;
    endtask

    initial begin
        header_regs.marker_native = 8'd1;
        header_regs.marker_console_a = 8'd2;
        header_regs.marker_console_b = 8'd3;
        header_regs.report_ident = 8'd0;
        header_regs.report_kind_byte = 8'd0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_flags[i] = 8'd0;
            slot_payload[i] = '0;
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_fill_and_drain();
        test_register_extremes();
        test_random_traffic(0, 0, 110);
        test_random_traffic(66, 0, 110);
        test_random_traffic(0, 66, 110);
        test_random_traffic(19, 19, 110);
        test_output_hold();
        test_sender_pause();

        wait_for_results();
        repeat (16) @(posedge i_clk);
        $display("Sent %0d requests: %0d stored, %0d refused, %0d reports, %0d failed encodes.",
                 n_requests, n_stored, n_refused, n_reports, n_failed_encodes);
        $display("Checked %0d result items with %0d drained records under four idle mixes.",
                 n_checked, n_drained);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
